### sv/shfc_pkg.sv
// Shared types, constants and the CRC-32 byte update for the header framer.
// Used by every module of the stream header framer; depends on nothing.
package shfc_pkg;

  localparam int FRAME_BYTES = 64;
  localparam int BODY_BYTES  = 60;
  localparam int QUEUE_DEPTH = 2;

  localparam int IN_W  = 416;
  localparam int OUT_W = 16;

  localparam logic [31:0] MAGIC_WORD   = 32'h4D4D_5332;
  localparam logic [15:0] HEADER_LEN   = 16'd64;
  localparam logic [15:0] VERSION_RST  = 16'd1;
  localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT     = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_XOROUT   = 32'hFFFF_FFFF;
  localparam logic [5:0]  LAST_POS     = 6'(FRAME_BYTES - 1);

  typedef logic [BODY_BYTES-1:0][7:0] body_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
    logic [31:0] c;
    c = crc ^ {24'd0, data};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

### sv/shfc_front.sv
// Front end: holds the version register, accepts header records and lays
// out the first 60 frame bytes. Depends on shfc_pkg.
module shfc_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [15:0]              cfg_wdata,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [shfc_pkg::IN_W-1:0] s_tdata,
  input  shfc_pkg::q_stat_t        q_stat,
  output logic                     push,
  output shfc_pkg::body_t          push_body
);

  logic [15:0]                             version;
  logic [8*shfc_pkg::BODY_BYTES-1:0]       be;

  always_ff @(posedge clk) begin
    if (rst) begin
      version <= shfc_pkg::VERSION_RST;
    end else if (cfg_we) begin
      version <= cfg_wdata;
    end
  end

  assign s_tready = !q_stat.full;
  assign push     = s_tvalid && s_tready;

  assign be = {shfc_pkg::MAGIC_WORD, version, shfc_pkg::HEADER_LEN,
               s_tdata[15:0], s_tdata[31:16], s_tdata[63:32], s_tdata[95:64],
               s_tdata[127:96], s_tdata[191:128], s_tdata[255:192],
               s_tdata[319:256], s_tdata[351:320], s_tdata[383:352],
               s_tdata[415:384]};

  always_comb begin
    for (int i = 0; i < shfc_pkg::BODY_BYTES; i++) begin
      push_body[i] = be[8*(shfc_pkg::BODY_BYTES-1-i) +: 8];
    end
  end

endmodule

### sv/shfc_queue.sv
// Short queue of laid-out frame bodies between the front and back ends.
// Depends on shfc_pkg.
module shfc_queue #(
  parameter int DEPTH = shfc_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  shfc_pkg::body_t   push_body,
  input  logic              pop,
  output shfc_pkg::body_t   head,
  output shfc_pkg::q_stat_t stat
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  shfc_pkg::body_t entries [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign stat.full  = (count == CW'(DEPTH));
  assign stat.empty = (count == '0);
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_body;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### sv/shfc_back.sv
// Back end: sends the queued frame one byte per transfer, folds bytes 0 to 59
// into a running CRC-32 and appends it big-endian. Depends on shfc_pkg.
module shfc_back (
  input  logic                       clk,
  input  logic                       rst,
  input  shfc_pkg::body_t            head,
  input  shfc_pkg::q_stat_t          q_stat,
  output logic                       pop,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [shfc_pkg::OUT_W-1:0] m_tdata,
  output logic                       m_tlast
);

  logic [5:0]  pos;
  logic [31:0] crc;
  logic [31:0] crc_fin;
  logic        advance;
  logic        fire;
  logic        in_body;
  logic [7:0]  crc_sel;
  logic [7:0]  byte_sel;

  assign advance = !m_tvalid || m_tready;
  assign fire    = advance && !q_stat.empty;
  assign pop     = fire && (pos == shfc_pkg::LAST_POS);
  assign in_body = (pos < 6'(shfc_pkg::BODY_BYTES));
  assign crc_fin = crc ^ shfc_pkg::CRC_XOROUT;

  always_comb begin
    unique case (pos[1:0])
      2'd0: crc_sel = crc_fin[31:24];
      2'd1: crc_sel = crc_fin[23:16];
      2'd2: crc_sel = crc_fin[15:8];
      default: crc_sel = crc_fin[7:0];
    endcase
    byte_sel = in_body ? head[pos] : crc_sel;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      pos      <= '0;
      crc      <= shfc_pkg::CRC_INIT;
    end else begin
      if (advance) begin
        m_tvalid <= !q_stat.empty;
      end
      if (fire) begin
        pos <= pos + 1'b1;
        if (pos == shfc_pkg::LAST_POS) begin
          crc <= shfc_pkg::CRC_INIT;
        end else if (in_body) begin
          crc <= shfc_pkg::crc_byte(crc, byte_sel);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_tdata <= {2'b00, pos, byte_sel};
      m_tlast <= (pos == shfc_pkg::LAST_POS);
    end
  end

endmodule

### sv/stream_header_framer_crc32_unit.sv
// Stream header framer: one header record in, one 64-byte frame out, one byte
// per transfer, the last four bytes carrying the CRC-32 of the first sixty.
// A record is written into the queue, and its first byte then into the output register.
// Throughput: one output byte per cycle while m_tready holds, set by the
// byte-wide output; records are taken while a frame is going out, until the queue is full.
// Reset (rst, synchronous): queue and output empty, version register 1.
module stream_header_framer_crc32_unit #(
  parameter int QUEUE_DEPTH = shfc_pkg::QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [15:0]                cfg_wdata,   // protocol_version
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // stream_number, format_code, flag_bits, session_number, instance_number,
  // sequence_number, start_time_us, end_time_us, payload_length,
  // auxiliary_word, payload_check
  input  logic [shfc_pkg::IN_W-1:0]  s_tdata,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [shfc_pkg::OUT_W-1:0] m_tdata,     // frame_byte, byte_position, zero pad
  output logic                       m_tlast      // last_byte
);

  shfc_pkg::q_stat_t q_stat;
  shfc_pkg::body_t   push_body;
  shfc_pkg::body_t   head;
  logic              push;
  logic              pop;

  shfc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .q_stat    (q_stat),
    .push      (push),
    .push_body (push_body)
  );

  shfc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_body (push_body),
    .pop       (pop),
    .head      (head),
    .stat      (q_stat)
  );

  shfc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_stat   (q_stat),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

### sv/shfc_checker.sv
// Port-level checks on the framer's output stream, bound to the top level.
// Depends on shfc_pkg and stream_header_framer_crc32_unit.
module shfc_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [shfc_pkg::OUT_W-1:0] m_tdata,
  input logic                       m_tlast
);

  a_last_at_end: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (m_tdata[13:8] == shfc_pkg::LAST_POS)))
    else $error("tlast does not match the final byte position");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output changed while stalled");

  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=>
      m_tvalid && (m_tdata[13:8] == $past(m_tdata[13:8]) + 6'd1))
    else $error("frame bytes not contiguous");

  a_magic: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[13:8] == 6'd0) |-> (m_tdata[7:0] == 8'h4D))
    else $error("frame does not open with the magic");

endmodule

bind stream_header_framer_crc32_unit shfc_checker u_shfc_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

### dv/tb_stream_header_framer_crc32_unit.sv
// Self-checking testbench for the stream header framer: sends header records,
// predicts each 64-byte frame with its trailing CRC-32 and checks every byte.
// Depends on shfc_pkg and stream_header_framer_crc32_unit.
`timescale 1ns / 100ps

module tb_stream_header_framer_crc32_unit;

  localparam logic [31:0] FRAME_TAG    = "MMS2";
  localparam logic [15:0] FRAME_LENGTH = 16'd64;
  localparam logic [31:0] CRC_REFLECT  = 32'hEDB8_8320;
  localparam logic [31:0] CRC_ONES     = 32'hFFFF_FFFF;
  localparam int          TAIL_CYCLES  = 20;

  typedef struct {
    logic [15:0] stream_number;
    logic [15:0] format_code;
    logic [31:0] flag_bits;
    logic [31:0] session_number;
    logic [31:0] instance_number;
    logic [63:0] sequence_number;
    logic [63:0] start_time_us;
    logic [63:0] end_time_us;
    logic [31:0] payload_length;
    logic [31:0] auxiliary_word;
    logic [31:0] payload_check;
  } header_rec_t;

  typedef struct {
    logic [7:0] value;
    logic [5:0] position;
    logic       last;
  } frame_byte_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_we = 1'b0;
  logic [15:0]                cfg_wdata = '0;
  logic                       s_tvalid = 1'b0;
  logic                       s_tready;
  logic [shfc_pkg::IN_W-1:0]  s_tdata = '0;
  logic                       m_tvalid;
  logic                       m_tready = 1'b0;
  logic [shfc_pkg::OUT_W-1:0] m_tdata;
  logic                       m_tlast;

  frame_byte_t pending_bytes[$];
  logic [15:0] version_reg = 16'd1;
  bit          tx_gaps_on = 1'b1;
  bit          rx_stalls_on = 1'b1;
  int          stall_left = 0;
  int          error_count = 0;
  int          records_sent = 0;
  int          bytes_checked = 0;
  int          version_writes = 0;

  stream_header_framer_crc32_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  always #5 clk = ~clk;

  function automatic logic [shfc_pkg::IN_W-1:0] pack_header(input header_rec_t h);
    return {h.payload_check, h.auxiliary_word, h.payload_length, h.end_time_us,
            h.start_time_us, h.sequence_number, h.instance_number, h.session_number,
            h.flag_bits, h.format_code, h.stream_number};
  endfunction

  function automatic logic [shfc_pkg::IN_W-1:0] random_noise();
    logic [shfc_pkg::IN_W-1:0] v;
    v = '0;
    for (int i = 0; i < shfc_pkg::IN_W; i += 32) begin
      v = (v << 32) | shfc_pkg::IN_W'($urandom);
    end
    return v;
  endfunction

  // Mostly random values, with a fair share of all-zero and all-one fields.
  function automatic logic [63:0] random_value();
    int pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) return 64'd0;
    if (pick == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  function automatic header_rec_t random_header();
    header_rec_t h;
    h.stream_number   = 16'(random_value());
    h.format_code     = 16'(random_value());
    h.flag_bits       = 32'(random_value());
    h.session_number  = 32'(random_value());
    h.instance_number = 32'(random_value());
    h.sequence_number = random_value();
    h.start_time_us   = random_value();
    h.end_time_us     = random_value();
    h.payload_length  = 32'(random_value());
    h.auxiliary_word  = 32'(random_value());
    h.payload_check   = 32'(random_value());
    return h;
  endfunction

  function automatic header_rec_t filled_header(input logic [63:0] fill);
    header_rec_t h;
    h.stream_number   = 16'(fill);
    h.format_code     = 16'(fill);
    h.flag_bits       = 32'(fill);
    h.session_number  = 32'(fill);
    h.instance_number = 32'(fill);
    h.sequence_number = fill;
    h.start_time_us   = fill;
    h.end_time_us     = fill;
    h.payload_length  = 32'(fill);
    h.auxiliary_word  = 32'(fill);
    h.payload_check   = 32'(fill);
    return h;
  endfunction

  // Builds the expected frame for one record and queues its 64 bytes.
  task automatic queue_frame_bytes(input header_rec_t h);
    logic [479:0] body;
    logic [31:0]  crc;
    logic [7:0]   frame [64];
    frame_byte_t  fb;
    body = {FRAME_TAG, version_reg, FRAME_LENGTH, h.stream_number, h.format_code,
            h.flag_bits, h.session_number, h.instance_number, h.sequence_number,
            h.start_time_us, h.end_time_us, h.payload_length, h.auxiliary_word,
            h.payload_check};
    crc = CRC_ONES;
    for (int k = 0; k < 60; k++) begin
      frame[k] = body[479 - 8 * k -: 8];
      crc = crc ^ {24'd0, frame[k]};
      for (int b = 0; b < 8; b++) begin
        crc = (crc >> 1) ^ (crc[0] ? CRC_REFLECT : 32'd0);
      end
    end
    crc = crc ^ CRC_ONES;
    for (int k = 0; k < 4; k++) begin
      frame[60 + k] = crc[31 - 8 * k -: 8];
    end
    for (int k = 0; k < 64; k++) begin
      fb.value    = frame[k];
      fb.position = 6'(k);
      fb.last     = (k == 63);
      pending_bytes.push_back(fb);
    end
  endtask

  task automatic send_header(input header_rec_t h);
    int gap;
    @(negedge clk);
    if (tx_gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      s_tvalid <= 1'b0;
      s_tdata  <= random_noise();
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= pack_header(h);
    do @(posedge clk); while (!s_tready);
    queue_frame_bytes(h);
    records_sent++;
  endtask

  task automatic wait_frames_done();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_version(input logic [15:0] v);
    wait_frames_done();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cfg_wdata <= 16'($urandom);
    version_reg = v;
    version_writes++;
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    error_count++;
    if (error_count <= 30) begin
      $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    end
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (rx_stalls_on && $urandom_range(0, 7) == 0) begin
      m_tready   <= 1'b0;
      stall_left <= $urandom_range(0, 3);
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    frame_byte_t fb;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_bytes.size() == 0) begin
        report_mismatch("unexpected transfer, byte", m_tdata[7:0], 0);
      end else begin
        fb = pending_bytes.pop_front();
        bytes_checked++;
        if (m_tdata[7:0] !== fb.value) report_mismatch("frame_byte", m_tdata[7:0], fb.value);
        if (m_tdata[13:8] !== fb.position) begin
          report_mismatch("byte_position", m_tdata[13:8], fb.position);
        end
        if (m_tlast !== fb.last) report_mismatch("last_byte", m_tlast, fb.last);
      end
    end
  end

  // The version register is left at its reset value here.
  task automatic test_reset_version();
    send_header(filled_header(64'd0));
    send_header(filled_header('1));
  endtask

  task automatic test_field_extremes();
    header_rec_t h;
    write_version(16'h0000);
    send_header(filled_header({16{4'hA}}));
    send_header(filled_header({16{4'h5}}));
    for (int f = 0; f < 11; f++) begin
      h = filled_header(64'd0);
      case (f)
        0:  h.stream_number   = '1;
        1:  h.format_code     = '1;
        2:  h.flag_bits       = '1;
        3:  h.session_number  = '1;
        4:  h.instance_number = '1;
        5:  h.sequence_number = '1;
        6:  h.start_time_us   = '1;
        7:  h.end_time_us     = '1;
        8:  h.payload_length  = '1;
        9:  h.auxiliary_word  = '1;
        default: h.payload_check = '1;
      endcase
      send_header(h);
    end
  endtask

  task automatic test_version_extremes();
    write_version(16'hFFFF);
    send_header(filled_header(64'd0));
    send_header(random_header());
    write_version(16'h8001);
    send_header(filled_header('1));
  endtask

  task automatic test_random_headers();
    for (int phase = 0; phase < 4; phase++) begin
      write_version(16'($urandom));
      for (int n = 0; n < 45; n++) send_header(random_header());
    end
  endtask

  // Final stretch with no gaps on either side to run at full rate.
  task automatic test_back_to_back();
    write_version(16'($urandom));
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b0;
    for (int n = 0; n < 20; n++) send_header(random_header());
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    test_reset_version();
    test_field_extremes();
    test_version_extremes();
    test_random_headers();
    test_back_to_back();
    wait_frames_done();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Run covered %0d header records and %0d frame bytes under %0d version writes.",
             records_sent, bytes_checked, version_writes);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Timed out with %0d frame bytes still expected.", pending_bytes.size());
    $display("Verification failed");
    $finish;
  end

endmodule
